### hdl/vfvg_pkg.sv
// ----------------------------------------------------------------------------
// vfvg_pkg
// Shared types and constants of the voxel face visibility grid: chunk
// geometry, cell type width, register indexes, sequencer steps and the
// command/status words between controller and datapath.
// ----------------------------------------------------------------------------
package vfvg_pkg;

	// Chunk geometry and cell type width
	localparam int SIDE       = 16;
	localparam int TYPE_BITS  = 8;
	localparam int COORD_BITS = 4;
	localparam int FIELD_BITS = 8;
	localparam int CELLS      = SIDE * SIDE * SIDE;
	localparam int ADDR_BITS  = $clog2(CELLS);
	localparam int FACE_BITS  = 6;

	typedef logic [TYPE_BITS-1:0]  cell_t;
	typedef logic [ADDR_BITS-1:0]  addr_t;
	typedef logic [COORD_BITS-1:0] coord_t;

	localparam coord_t COORD_MAX  = COORD_BITS'(SIDE - 1);
	localparam addr_t  DELTA_X    = ADDR_BITS'(SIDE * SIDE);
	localparam addr_t  DELTA_Y    = ADDR_BITS'(SIDE);
	localparam addr_t  DELTA_Z    = ADDR_BITS'(1);
	localparam addr_t  LAST_ADDR  = ADDR_BITS'(CELLS - 1);

	// Operation codes
	localparam logic OP_PUT = 1'b0;
	localparam logic OP_GET = 1'b1;

	// Register indexes
	localparam int   CFG_INDEX_BITS    = 1;
	localparam logic CFG_BORDER_IS_AIR = 1'b0;
	localparam logic CFG_AIR_CODE      = 1'b1;

	// Read sequence: center first, then neighbors in mask bit order
	localparam int STEP_BITS = 3;
	localparam logic [STEP_BITS-1:0] STEP_CENTER = 3'd0;
	localparam logic [STEP_BITS-1:0] STEP_XP     = 3'd1;
	localparam logic [STEP_BITS-1:0] STEP_XN     = 3'd2;
	localparam logic [STEP_BITS-1:0] STEP_YP     = 3'd3;
	localparam logic [STEP_BITS-1:0] STEP_YN     = 3'd4;
	localparam logic [STEP_BITS-1:0] STEP_ZP     = 3'd5;
	localparam logic [STEP_BITS-1:0] STEP_ZN     = 3'd6;
	localparam logic [STEP_BITS-1:0] STEP_LAST   = 3'd7;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic                 clear_wr;
		logic                 load;
		logic                 issue;
		logic                 capture;
		logic                 finish;
		logic [STEP_BITS-1:0] step;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_last;
		logic in_range;
		logic out_free;
	} dp_status_t;

endpackage

### hdl/voxel_face_visibility_grid.sv
// ----------------------------------------------------------------------------
// voxel_face_visibility_grid
// One cubic chunk of voxel cell types with put/get and a six-bit face
// visibility mask per result, worked out from the cell and its neighbors.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | op, x_coord, y_coord, z_coord, cell_type
//  out     | out_valid / out_stall| stored_type, face_mask, changed
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  An in-range word goes from accept through seven reads on the single read
//  port of the cell store, then capture, finish and idle; finish waits while
//  a stalled result holds the output register. An out-of-range word goes from accept straight to finish.
//  After reset a clearing pass writes air to all 4096 cells, one a cycle;
//  in_stall stays high until the pass is done. cfg_ready is always high.
//  A result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module voxel_face_visibility_grid (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [vfvg_pkg::COORD_BITS-1:0]     x_coord,
	input  logic [vfvg_pkg::COORD_BITS-1:0]     y_coord,
	input  logic [vfvg_pkg::COORD_BITS-1:0]     z_coord,
	input  logic [vfvg_pkg::FIELD_BITS-1:0]     cell_type,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [vfvg_pkg::FIELD_BITS-1:0]     stored_type,
	output logic [vfvg_pkg::FACE_BITS-1:0]      face_mask,
	output logic                                changed,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vfvg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [vfvg_pkg::FIELD_BITS-1:0]     cfg_data
);

	vfvg_pkg::ctrl_cmd_t  cmd;
	vfvg_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	// Sequencer
	vfvg_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Store and result path
	vfvg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.z_coord     (z_coord),
		.cell_type   (cell_type),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.stored_type (stored_type),
		.face_mask   (face_mask),
		.changed     (changed)
	);

endmodule

### hdl/vfvg_datapath.sv
// ----------------------------------------------------------------------------
// vfvg_datapath
// Cell store, configuration registers, neighbor address generation, face
// mask assembly and the output word register.
// ----------------------------------------------------------------------------
module vfvg_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  vfvg_pkg::ctrl_cmd_t                    cmd,
	output vfvg_pkg::dp_status_t                   status,
	input  logic                                   cfg_valid,
	input  logic [vfvg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [vfvg_pkg::FIELD_BITS-1:0]        cfg_data,
	input  logic                                   op,
	input  logic [vfvg_pkg::COORD_BITS-1:0]        x_coord,
	input  logic [vfvg_pkg::COORD_BITS-1:0]        y_coord,
	input  logic [vfvg_pkg::COORD_BITS-1:0]        z_coord,
	input  logic [vfvg_pkg::FIELD_BITS-1:0]        cell_type,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [vfvg_pkg::FIELD_BITS-1:0]        stored_type,
	output logic [vfvg_pkg::FACE_BITS-1:0]         face_mask,
	output logic                                   changed
);

	// Cell store
	vfvg_pkg::cell_t mem [vfvg_pkg::CELLS];

	logic                                border_is_air_q;
	logic [vfvg_pkg::FIELD_BITS-1:0]     air_code_q;
	vfvg_pkg::cell_t                     air_t;

	vfvg_pkg::addr_t                     clr_addr_q;

	logic                                op_q;
	vfvg_pkg::coord_t                    x_q;
	vfvg_pkg::coord_t                    y_q;
	vfvg_pkg::coord_t                    z_q;
	vfvg_pkg::cell_t                     new_q;
	vfvg_pkg::addr_t                     base_q;
	logic                                in_range_q;
	logic                                in_range;

	vfvg_pkg::addr_t                     rd_addr;
	logic                                nb_outside;
	vfvg_pkg::cell_t                     rdata_s1;
	logic                                outside_s1;
	logic                                center_s1;
	logic                                air_flag;

	vfvg_pkg::cell_t                     center_q;
	logic                                changed_q;
	logic [vfvg_pkg::FACE_BITS-1:0]      mask_q;

	logic                                out_valid_q;
	logic                                wr_en;
	vfvg_pkg::addr_t                     wr_addr;
	vfvg_pkg::cell_t                     wr_data;

	assign air_t = vfvg_pkg::cell_t'(air_code_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			border_is_air_q <= 1'b1;
			air_code_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vfvg_pkg::CFG_BORDER_IS_AIR: border_is_air_q <= cfg_data[0];
				vfvg_pkg::CFG_AIR_CODE:      air_code_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Range check of the incoming word
	assign in_range = (int'(x_coord) < vfvg_pkg::SIDE) &&
	                  (int'(y_coord) < vfvg_pkg::SIDE) &&
	                  (int'(z_coord) < vfvg_pkg::SIDE);

	// Capture the accepted word and its linear address
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= op;
			x_q        <= x_coord;
			y_q        <= y_coord;
			z_q        <= z_coord;
			new_q      <= vfvg_pkg::cell_t'(cell_type);
			in_range_q <= in_range;
			base_q     <= vfvg_pkg::ADDR_BITS'(int'(x_coord) * vfvg_pkg::SIDE * vfvg_pkg::SIDE +
			                                   int'(y_coord) * vfvg_pkg::SIDE + int'(z_coord));
		end
	end

	// Neighbor address and border flag for the current step
	always_comb begin
		rd_addr    = base_q;
		nb_outside = 1'b0;
		unique case (cmd.step)
			vfvg_pkg::STEP_CENTER: begin
				rd_addr    = base_q;
				nb_outside = 1'b0;
			end
			vfvg_pkg::STEP_XP: begin
				rd_addr    = base_q + vfvg_pkg::DELTA_X;
				nb_outside = (x_q == vfvg_pkg::COORD_MAX);
			end
			vfvg_pkg::STEP_XN: begin
				rd_addr    = base_q - vfvg_pkg::DELTA_X;
				nb_outside = (x_q == '0);
			end
			vfvg_pkg::STEP_YP: begin
				rd_addr    = base_q + vfvg_pkg::DELTA_Y;
				nb_outside = (y_q == vfvg_pkg::COORD_MAX);
			end
			vfvg_pkg::STEP_YN: begin
				rd_addr    = base_q - vfvg_pkg::DELTA_Y;
				nb_outside = (y_q == '0);
			end
			vfvg_pkg::STEP_ZP: begin
				rd_addr    = base_q + vfvg_pkg::DELTA_Z;
				nb_outside = (z_q == vfvg_pkg::COORD_MAX);
			end
			vfvg_pkg::STEP_ZN: begin
				rd_addr    = base_q - vfvg_pkg::DELTA_Z;
				nb_outside = (z_q == '0);
			end
			default: begin
				rd_addr    = base_q;
				nb_outside = 1'b0;
			end
		endcase
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rdata_s1   <= mem[rd_addr];
			outside_s1 <= nb_outside;
			center_s1  <= (cmd.step == vfvg_pkg::STEP_CENTER);
		end
	end

	// Write port: clearing sweep after reset, or the put at finish
	assign wr_en   = cmd.clear_wr || (cmd.finish && in_range_q && (op_q == vfvg_pkg::OP_PUT));
	assign wr_addr = cmd.clear_wr ? clr_addr_q : base_q;
	assign wr_data = cmd.clear_wr ? '0 : new_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Advance the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Collect center type and neighbor air flags
	assign air_flag = outside_s1 ? border_is_air_q : (rdata_s1 == air_t);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			if (center_s1) begin
				center_q  <= (op_q == vfvg_pkg::OP_PUT) ? new_q : rdata_s1;
				changed_q <= (op_q == vfvg_pkg::OP_PUT) && (rdata_s1 != new_q);
			end else begin
				mask_q <= {mask_q[vfvg_pkg::FACE_BITS-2:0], air_flag};
			end
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			stored_type <= in_range_q ? vfvg_pkg::FIELD_BITS'(center_q) : air_code_q;
			face_mask   <= (!in_range_q || (center_q == air_t)) ? '0 : mask_q;
			changed     <= in_range_q && changed_q;
		end
	end

	assign out_valid = out_valid_q;

	assign status.clear_last = (clr_addr_q == vfvg_pkg::LAST_ADDR);
	assign status.in_range   = in_range;
	assign status.out_free   = !out_valid_q || !out_stall;

endmodule

### hdl/vfvg_controller.sv
// ----------------------------------------------------------------------------
// vfvg_controller
// Sequencer: clearing sweep after reset, word accept, seven store reads
// (center and six neighbors) and the finish step that loads the output.
// ----------------------------------------------------------------------------
module vfvg_controller (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  vfvg_pkg::dp_status_t  status,
	output vfvg_pkg::ctrl_cmd_t   cmd
);

	vfvg_pkg::state_t                       state_q;
	vfvg_pkg::state_t                       state_d;
	logic [vfvg_pkg::STEP_BITS-1:0]         step_q;
	logic [vfvg_pkg::STEP_BITS-1:0]         step_d;

	// State and step registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfvg_pkg::ST_CLEAR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		cmd         = '0;
		cmd.step    = step_q;
		in_stall    = 1'b1;
		unique case (state_q)
			vfvg_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_last) begin
					state_d = vfvg_pkg::ST_IDLE;
				end
			end
			vfvg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				step_d   = vfvg_pkg::STEP_CENTER;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.in_range ? vfvg_pkg::ST_RUN : vfvg_pkg::ST_FINISH;
				end
			end
			vfvg_pkg::ST_RUN: begin
				// one read issued per step, its data taken at the next step
				cmd.issue   = (step_q != vfvg_pkg::STEP_LAST);
				cmd.capture = (step_q != vfvg_pkg::STEP_CENTER);
				step_d      = step_q + 1'b1;
				if (step_q == vfvg_pkg::STEP_LAST) begin
					state_d = vfvg_pkg::ST_FINISH;
				end
			end
			vfvg_pkg::ST_FINISH: begin
				// hold until the output register is free
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = vfvg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vfvg_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives put/get words into the voxel face visibility grid and checks every
// result word against a cycle-free model of the chunk. The model keeps its
// own copy of the cell store and both registers, and works out each word's
// stored type, change flag and face mask when the word is accepted. Stimulus
// is a short directed run followed by random words, mostly clustered near a
// moving focus point so that neighbors interact. The run goes through several
// register settings. Both sides idle in short random bursts except at the end.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic             op;
		vfvg_pkg::coord_t x;
		vfvg_pkg::coord_t y;
		vfvg_pkg::coord_t z;
		vfvg_pkg::cell_t  kind;
	} voxel_cmd_t;

	typedef struct packed {
		vfvg_pkg::cell_t                stored;
		logic [vfvg_pkg::FACE_BITS-1:0] faces;
		logic                           chg;
	} voxel_result_t;

	logic                                clk;
	logic                                arst_n    = 1'b0;
	logic                                in_valid  = 1'b0;
	logic                                in_stall;
	logic                                op        = vfvg_pkg::OP_GET;
	vfvg_pkg::coord_t                    x_coord   = '0;
	vfvg_pkg::coord_t                    y_coord   = '0;
	vfvg_pkg::coord_t                    z_coord   = '0;
	logic [vfvg_pkg::FIELD_BITS-1:0]     cell_type = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic [vfvg_pkg::FIELD_BITS-1:0]     stored_type;
	logic [vfvg_pkg::FACE_BITS-1:0]      face_mask;
	logic                                changed;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [vfvg_pkg::CFG_INDEX_BITS-1:0] cfg_index = vfvg_pkg::CFG_BORDER_IS_AIR;
	logic [vfvg_pkg::FIELD_BITS-1:0]     cfg_data  = '0;

	// Model state
	vfvg_pkg::cell_t cell_store [vfvg_pkg::CELLS];
	bit              model_border_air = 1'b1;
	vfvg_pkg::cell_t model_air_code   = '0;

	voxel_cmd_t    cmd_queue[$];
	voxel_result_t expected_cells[$];
	voxel_cmd_t    drive_cmd;
	bit            in_accepted = 1'b0;
	bit            idle_on     = 1'b1;
	int            gap_left    = 0;
	int            stall_left  = 0;
	int            fail_count  = 0;

	voxel_face_visibility_grid dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.z_coord    (z_coord),
		.cell_type  (cell_type),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.stored_type(stored_type),
		.face_mask  (face_mask),
		.changed    (changed),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Outside the chunk the border register decides
	function automatic bit neighbor_air(int x, int y, int z);
		if (x < 0 || x >= vfvg_pkg::SIDE || y < 0 || y >= vfvg_pkg::SIDE ||
		    z < 0 || z >= vfvg_pkg::SIDE)
			return model_border_air;
		return cell_store[vfvg_pkg::addr_t'((x * vfvg_pkg::SIDE + y) * vfvg_pkg::SIDE + z)]
		       == model_air_code;
	endfunction

	// Track register writes and predict each accepted word
	always @(posedge clk) begin : watch_inputs
		voxel_result_t   res;
		int              cx, cy, cz;
		vfvg_pkg::addr_t idx;
		in_accepted = arst_n && in_valid && (in_stall === 1'b0);
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == vfvg_pkg::CFG_BORDER_IS_AIR)
				model_border_air = cfg_data[0];
			else
				model_air_code = vfvg_pkg::cell_t'(cfg_data);
		end
		if (in_accepted) begin
			cx = int'(x_coord);
			cy = int'(y_coord);
			cz = int'(z_coord);
			idx = vfvg_pkg::addr_t'((cx * vfvg_pkg::SIDE + cy) * vfvg_pkg::SIDE + cz);
			res.chg = 1'b0;
			if (op == vfvg_pkg::OP_PUT && cell_store[idx] != vfvg_pkg::cell_t'(cell_type)) begin
				cell_store[idx] = vfvg_pkg::cell_t'(cell_type);
				res.chg = 1'b1;
			end
			res.stored = cell_store[idx];
			res.faces = '0;
			if (cell_store[idx] != model_air_code) begin
				res.faces[5] = neighbor_air(cx + 1, cy, cz);
				res.faces[4] = neighbor_air(cx - 1, cy, cz);
				res.faces[3] = neighbor_air(cx, cy + 1, cz);
				res.faces[2] = neighbor_air(cx, cy - 1, cz);
				res.faces[1] = neighbor_air(cx, cy, cz + 1);
				res.faces[0] = neighbor_air(cx, cy, cz - 1);
			end
			expected_cells = {expected_cells, res};
		end
	end

	// Compare each result word with the oldest prediction
	always @(posedge clk) begin : watch_results
		voxel_result_t want;
		if (arst_n && out_valid && out_stall == 1'b0) begin
			if (expected_cells.size() == 0) begin
				$error("result word with nothing expected: stored_type %0d", stored_type);
				fail_count++;
			end else begin
				want = expected_cells.pop_front();
				if (stored_type !== want.stored) begin
					$error("stored_type: expected %0d, actual %0d", want.stored, stored_type);
					fail_count++;
				end
				if (face_mask !== want.faces) begin
					$error("face_mask: expected %b, actual %b", want.faces, face_mask);
					fail_count++;
				end
				if (changed !== want.chg) begin
					$error("changed: expected %0d, actual %0d", want.chg, changed);
					fail_count++;
				end
			end
		end
	end

	// Present the next word once the current one is taken; hold it while stalled
	always @(negedge clk) begin
		if (arst_n && (in_accepted || !in_valid)) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (cmd_queue.size() != 0) begin
				drive_cmd = cmd_queue.pop_front();
				op        <= drive_cmd.op;
				x_coord   <= drive_cmd.x;
				y_coord   <= drive_cmd.y;
				z_coord   <= drive_cmd.z;
				cell_type <= drive_cmd.kind;
				in_valid  <= 1'b1;
				if (idle_on && $urandom_range(0, 4) == 0)
					gap_left = $urandom_range(1, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Stall the result side in short bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (idle_on && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 3);
		end
	end

	task automatic queue_word(logic o, int x, int y, int z, vfvg_pkg::cell_t t);
		voxel_cmd_t c;
		c.op   = o;
		c.x    = vfvg_pkg::coord_t'(x);
		c.y    = vfvg_pkg::coord_t'(y);
		c.z    = vfvg_pkg::coord_t'(z);
		c.kind = t;
		cmd_queue = {cmd_queue, c};
	endtask

	// Mostly clustered words around a focus that moves every few dozen words;
	// the rest spread over the whole chunk
	task automatic queue_random_words(int count, vfvg_pkg::cell_t air);
		int              fx, fy, fz, c[3];
		vfvg_pkg::cell_t t;
		logic            o;
		fx = 0;
		fy = 0;
		fz = 0;
		for (int n = 0; n < count; n++) begin
			if (n % 32 == 0) begin
				fx = $urandom_range(0, 1) ? 15 * $urandom_range(0, 1) : $urandom_range(0, 15);
				fy = $urandom_range(0, 1) ? 15 * $urandom_range(0, 1) : $urandom_range(0, 15);
				fz = $urandom_range(0, 1) ? 15 * $urandom_range(0, 1) : $urandom_range(0, 15);
			end
			o = ($urandom_range(0, 9) < 7) ? vfvg_pkg::OP_PUT : vfvg_pkg::OP_GET;
			case ($urandom_range(0, 4))
				0, 1: t = air;
				2: t = vfvg_pkg::cell_t'($urandom_range(0, 255));
				default: t = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
			endcase
			if ($urandom_range(0, 9) < 8) begin
				c[0] = fx + $urandom_range(0, 2) - 1;
				c[1] = fy + $urandom_range(0, 2) - 1;
				c[2] = fz + $urandom_range(0, 2) - 1;
				foreach (c[i]) begin
					if (c[i] < 0)
						c[i] = 0;
					if (c[i] > 15)
						c[i] = 15;
				end
			end else begin
				o = 1'($urandom_range(0, 1));
				t = vfvg_pkg::cell_t'($urandom_range(0, 255));
				c[0] = $urandom_range(0, 15);
				c[1] = $urandom_range(0, 15);
				c[2] = $urandom_range(0, 15);
			end
			queue_word(o, c[0], c[1], c[2], t);
		end
	endtask

	task automatic wait_drained();
		while (cmd_queue.size() != 0 || in_valid || expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [vfvg_pkg::CFG_INDEX_BITS-1:0] idx,
	                         logic [vfvg_pkg::FIELD_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Main sequence
	initial begin : main_seq
		vfvg_pkg::cell_t air;
		foreach (cell_store[i])
			cell_store[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Corner, same-type put, neighbor hiding a face, back to air
		queue_word(vfvg_pkg::OP_PUT, 0, 0, 0, 8'hFF);
		queue_word(vfvg_pkg::OP_GET, 0, 0, 0, 8'h00);
		queue_word(vfvg_pkg::OP_PUT, 0, 0, 0, 8'hFF);
		queue_word(vfvg_pkg::OP_PUT, 1, 0, 0, 8'h55);
		queue_word(vfvg_pkg::OP_GET, 0, 0, 0, 8'hFF);
		queue_word(vfvg_pkg::OP_PUT, 15, 15, 15, 8'hAA);
		queue_word(vfvg_pkg::OP_GET, 15, 15, 15, 8'h00);
		queue_word(vfvg_pkg::OP_PUT, 15, 15, 15, 8'h00);
		queue_word(vfvg_pkg::OP_GET, 15, 15, 15, 8'hFF);
		// Fully enclosed cell, then open one face
		queue_word(vfvg_pkg::OP_PUT, 8, 8, 8, 8'h01);
		queue_word(vfvg_pkg::OP_PUT, 9, 8, 8, 8'h80);
		queue_word(vfvg_pkg::OP_PUT, 7, 8, 8, 8'h80);
		queue_word(vfvg_pkg::OP_PUT, 8, 9, 8, 8'h80);
		queue_word(vfvg_pkg::OP_PUT, 8, 7, 8, 8'h80);
		queue_word(vfvg_pkg::OP_PUT, 8, 8, 9, 8'h80);
		queue_word(vfvg_pkg::OP_PUT, 8, 8, 7, 8'h80);
		queue_word(vfvg_pkg::OP_GET, 8, 8, 8, 8'h00);
		queue_word(vfvg_pkg::OP_PUT, 8, 8, 9, 8'h00);
		queue_word(vfvg_pkg::OP_GET, 8, 8, 8, 8'h00);
		queue_word(vfvg_pkg::OP_PUT, 0, 15, 0, 8'hFF);
		queue_word(vfvg_pkg::OP_GET, 15, 0, 15, 8'hFF);
		queue_random_words(350, 8'h00);
		wait_drained();

		// Solid border: corner faces vanish
		write_reg(vfvg_pkg::CFG_BORDER_IS_AIR, 8'h00);
		queue_word(vfvg_pkg::OP_GET, 0, 0, 0, 8'h00);
		queue_word(vfvg_pkg::OP_GET, 0, 15, 0, 8'h00);
		queue_word(vfvg_pkg::OP_PUT, 15, 0, 15, 8'h3C);
		queue_random_words(300, 8'h00);
		wait_drained();

		// Top air code: reset cells now count as solid
		write_reg(vfvg_pkg::CFG_AIR_CODE, 8'hFF);
		write_reg(vfvg_pkg::CFG_BORDER_IS_AIR, 8'h01);
		queue_random_words(300, 8'hFF);
		wait_drained();

		air = vfvg_pkg::cell_t'($urandom_range(1, 254));
		write_reg(vfvg_pkg::CFG_AIR_CODE, air);
		write_reg(vfvg_pkg::CFG_BORDER_IS_AIR, 8'h00);
		queue_random_words(300, air);
		wait_drained();

		// Back to reset settings, no idling to the end
		write_reg(vfvg_pkg::CFG_BORDER_IS_AIR, 8'h01);
		write_reg(vfvg_pkg::CFG_AIR_CODE, 8'h00);
		idle_on = 1'b0;
		queue_random_words(200, 8'h00);
		wait_drained();

		if (expected_cells.size() != 0) begin
			$error("%0d result words never arrived", expected_cells.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
